### rtl/core/hpt_pkg.sv
// Shared types and constants for the homogeneous point transform.
// Holds the fixed-point format, datapath widths, operation codes and the
// command/status structs between the controller and the datapath.
package hpt_pkg;

  // Fixed-point format of the matrix, the inputs and the results
  localparam int FRAC_BITS = 16;

  // Row accumulator: three 64-bit products plus a shifted translation term
  localparam int ACC_W     = 66;
  // Row sum after dropping the fraction bits (floor)
  localparam int ROW_W     = ACC_W - FRAC_BITS;
  localparam int ROW_IDX_W = $clog2(ROW_W);

  // Quotient bits kept by the divider: 32 result bits plus one for overflow
  localparam int DIV_QW    = 33;
  localparam int QCNT_W    = $clog2(DIV_QW);

  localparam logic [31:0]       ONE_Q   = 32'(64'd1 << FRAC_BITS);
  localparam logic [DIV_QW-1:0] LIM_POS = DIV_QW'(64'h7FFF_FFFF);
  localparam logic [DIV_QW-1:0] LIM_NEG = DIV_QW'(64'h8000_0000);
  localparam logic [31:0]       MAX_S32 = 32'h7FFF_FFFF;
  localparam logic [31:0]       MIN_S32 = 32'h8000_0000;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_POINT = 2'd1,
    OP_DIR   = 2'd2
  } hpt_op_e;

  localparam logic [1:0] ROW_W_IDX = 2'd3;  // row holding w
  localparam logic [1:0] COL_TRANS = 2'd3;  // translation column
  localparam logic [1:0] LAST_COL  = 2'd2;
  localparam logic [1:0] LAST_ROW  = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic              mat_we;      // write one matrix element
    logic              capture;     // take the input vector, clear result flags
    logic              acc_init;    // start a row sum
    logic              with_trans;  // seed the row sum with the translation term
    logic              mul_en;      // multiply matrix element by vector component
    logic              acc_add;     // add the registered product
    logic [1:0]        row;
    logic [1:0]        col;
    logic              store_w;     // keep the row sum as w
    logic              set_dz;      // w is zero: flag it
    logic              store_clamp; // store the clamped row sum (direction)
    logic              div_ld;      // set up a divide of the row sum by w
    logic              div_step;    // one quotient bit
    logic [QCNT_W-1:0] div_bit;     // quotient bit being formed
    logic              store_div;   // store the quotient
    logic              out_load;    // move the result into the output register
  } hpt_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic w_zero;
  } hpt_sts_t;

endpackage

### rtl/core/homogeneous_point_transform.sv
// Top level of the homogeneous point transform: controller plus datapath.
// Depends on hpt_pkg, hpt_ctrl and hpt_datapath.
//
//   channel | direction | handshake             | word
//   --------+-----------+-----------------------+----------------------------------
//   in      | input     | in_valid_i/in_ready_o | operation, index, value, x, y, z
//   out     | output    | out_valid_o/out_ready_i | x, y, z, divide_by_zero, saturated
//
// A load word leaves the block idle, so the next word can be taken the cycle after.
// A direction forms three row sums on the single 32x32 multiplier, then
// moves the result into the output register.
// A point forms the w row sum, then per coordinate a row sum and a
// bit-serial divide by w; a zero w skips the divides.
// The output register frees the input side: a new word is taken while a result
// waits; a finished item stalls only if the previous result is still untaken.
// Reset loads the identity matrix at once; no clearing pass.
module homogeneous_point_transform
  import hpt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         operation_i,
  input  logic [3:0]         element_index_i,
  input  logic signed [31:0] element_value_i,
  input  logic signed [31:0] in_x_i,
  input  logic signed [31:0] in_y_i,
  input  logic signed [31:0] in_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic signed [31:0] out_z_o,
  output logic               divide_by_zero_o,
  output logic               saturated_o
);

  hpt_cmd_t cmd;
  hpt_sts_t sts;

  hpt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .operation_i (operation_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  hpt_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .element_index_i  (element_index_i),
    .element_value_i  (element_value_i),
    .in_x_i           (in_x_i),
    .in_y_i           (in_y_i),
    .in_z_i           (in_z_i),
    .out_x_o          (out_x_o),
    .out_y_o          (out_y_o),
    .out_z_o          (out_z_o),
    .divide_by_zero_o (divide_by_zero_o),
    .saturated_o      (saturated_o)
  );

  // A point or direction word keeps the block busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (operation_i == OP_POINT || operation_i == OP_DIR)
    |=> !in_ready_o)
    else $error("block took a new word while a transform was in progress");

  // A load leaves the input ready in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && operation_i == OP_LOAD |=> in_ready_o)
    else $error("load word did not free the input in one cycle");

  // A zero w gives zero coordinates and no saturation
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && divide_by_zero_o
    |-> out_x_o == 32'sd0 && out_y_o == 32'sd0 && out_z_o == 32'sd0 && !saturated_o)
    else $error("divide by zero result carries non-zero fields");

endmodule

### rtl/core/hpt_ctrl.sv
// Controller for the homogeneous point transform: sequences the row sums,
// the divides and the output register. Depends on hpt_pkg.
module hpt_ctrl
  import hpt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] operation_i,
  output logic       in_ready_o,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  input  hpt_sts_t   sts_i,
  output hpt_cmd_t   cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_TRANS,
    S_MUL,
    S_ADD,
    S_ROW,
    S_DIV_LD,
    S_DIV,
    S_DIV_END,
    S_OUT
  } state_e;

  state_e            state_q;
  logic [1:0]        row_q;
  logic [1:0]        col_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              point_q;
  logic              out_valid_q;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // Decode state into datapath commands
  always_comb begin
    cmd_o         = '0;
    cmd_o.row     = row_q;
    cmd_o.col     = col_q;
    cmd_o.div_bit = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (operation_i) inside
            OP_LOAD:         cmd_o.mat_we  = 1'b1;
            OP_POINT, OP_DIR: cmd_o.capture = 1'b1;
            default: ;
          endcase
        end
      end
      S_TRANS: begin
        cmd_o.acc_init   = 1'b1;
        cmd_o.with_trans = point_q;
        cmd_o.col        = COL_TRANS;
      end
      S_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.acc_add = (col_q != 2'd0);
      end
      S_ADD: cmd_o.acc_add = 1'b1;
      S_ROW: begin
        if (point_q) begin
          if (row_q == ROW_W_IDX) begin
            cmd_o.set_dz  = sts_i.w_zero;
            cmd_o.store_w = ~sts_i.w_zero;
          end
        end else begin
          cmd_o.store_clamp = 1'b1;
        end
      end
      S_DIV_LD:  cmd_o.div_ld    = 1'b1;
      S_DIV:     cmd_o.div_step  = 1'b1;
      S_DIV_END: cmd_o.store_div = 1'b1;
      S_OUT:     cmd_o.out_load  = ~out_valid_q | out_ready_i;
      default: ;
    endcase
  end

  // Hold state, counters and the output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      row_q       <= '0;
      col_q       <= '0;
      cnt_q       <= '0;
      point_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            unique case (operation_i)
              OP_POINT: begin
                point_q <= 1'b1;
                row_q   <= ROW_W_IDX;
                state_q <= S_TRANS;
              end
              OP_DIR: begin
                point_q <= 1'b0;
                row_q   <= '0;
                state_q <= S_TRANS;
              end
              default: ;
            endcase
          end
        end
        S_TRANS: begin
          col_q   <= '0;
          state_q <= S_MUL;
        end
        S_MUL: begin
          if (col_q == LAST_COL) begin
            state_q <= S_ADD;
          end else begin
            col_q <= col_q + 2'd1;
          end
        end
        S_ADD: state_q <= S_ROW;
        S_ROW: begin
          if (point_q) begin
            if (row_q == ROW_W_IDX) begin
              if (sts_i.w_zero) begin
                state_q <= S_OUT;
              end else begin
                row_q   <= '0;
                state_q <= S_TRANS;
              end
            end else begin
              state_q <= S_DIV_LD;
            end
          end else if (row_q == LAST_ROW) begin
            state_q <= S_OUT;
          end else begin
            row_q   <= row_q + 2'd1;
            state_q <= S_TRANS;
          end
        end
        S_DIV_LD: begin
          cnt_q   <= QCNT_W'(DIV_QW - 1);
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (cnt_q == '0) begin
            state_q <= S_DIV_END;
          end else begin
            cnt_q <= cnt_q - QCNT_W'(1);
          end
        end
        S_DIV_END: begin
          if (row_q == LAST_ROW) begin
            state_q <= S_OUT;
          end else begin
            row_q   <= row_q + 2'd1;
            state_q <= S_TRANS;
          end
        end
        S_OUT: begin
          if (cmd_o.out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/hpt_datapath.sv
// Datapath for the homogeneous point transform: matrix registers, shared
// multiply-accumulate, bit-serial divider, result and output registers.
// Depends on hpt_pkg.
module hpt_datapath
  import hpt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hpt_cmd_t           cmd_i,
  output hpt_sts_t           sts_o,
  input  logic [3:0]         element_index_i,
  input  logic signed [31:0] element_value_i,
  input  logic signed [31:0] in_x_i,
  input  logic signed [31:0] in_y_i,
  input  logic signed [31:0] in_z_i,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic signed [31:0] out_z_o,
  output logic               divide_by_zero_o,
  output logic               saturated_o
);

  logic [31:0]              mat_q [16];
  logic signed [31:0]       vec_q [3];
  logic signed [63:0]       prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ROW_W-1:0]  w_q;
  logic [ROW_W-1:0]         div_n_q;
  logic [ROW_W-1:0]         div_d_q;
  logic [ROW_W:0]           div_r_q;
  logic [DIV_QW-1:0]        div_quo_q;
  logic                     div_neg_q;
  logic                     div_ovf_q;
  logic [31:0]              res_q [3];
  logic                     dz_q;
  logic                     sat_q;
  logic [31:0]              out_x_q, out_y_q, out_z_q;
  logic                     out_dz_q, out_sat_q;

  logic [31:0]              mat_rd;
  logic signed [31:0]       vec_sel;
  logic signed [ROW_W-1:0]  row_s;
  logic [ROW_W-1:0]         num_mag, den_mag, rem0;
  logic [ROW_IDX_W-1:0]     nsel;
  logic                     nbit;
  logic [ROW_W:0]           rem_sh;
  logic                     rem_ge;
  logic [DIV_QW-1:0]        lim, quo_mag;
  logic                     quo_sat;
  logic [31:0]              div_res;
  logic                     row_fits;
  logic [31:0]              clamp_res;

  // Read one matrix element and pick the vector component
  assign mat_rd = mat_q[{cmd_i.row, cmd_i.col}];

  always_comb begin
    case (cmd_i.col)
      2'd0:    vec_sel = vec_q[0];
      2'd1:    vec_sel = vec_q[1];
      default: vec_sel = vec_q[2];
    endcase
  end

  // Row sum with fraction dropped (floor)
  assign row_s        = acc_q[ACC_W-1:FRAC_BITS];
  assign sts_o.w_zero = (row_s == '0);

  // Divider set-up: magnitudes and the top part of the shifted numerator
  assign num_mag = row_s[ROW_W-1] ? ROW_W'(-row_s) : ROW_W'(row_s);
  assign den_mag = w_q[ROW_W-1]   ? ROW_W'(-w_q)   : ROW_W'(w_q);
  assign rem0    = num_mag >> (DIV_QW - FRAC_BITS);

  // One restoring step: bring in the next numerator bit, subtract if it fits
  assign nsel   = ROW_IDX_W'(cmd_i.div_bit - QCNT_W'(FRAC_BITS));
  assign nbit   = (cmd_i.div_bit >= QCNT_W'(FRAC_BITS)) ? div_n_q[nsel] : 1'b0;
  assign rem_sh = {div_r_q[ROW_W-1:0], nbit};
  assign rem_ge = (rem_sh >= {1'b0, div_d_q});

  // Clamp the quotient to the signed 32-bit range and apply the sign
  assign lim     = div_neg_q ? LIM_NEG : LIM_POS;
  assign quo_sat = div_ovf_q | (div_quo_q > lim);
  assign quo_mag = quo_sat ? lim : div_quo_q;
  assign div_res = div_neg_q ? 32'(-quo_mag) : quo_mag[31:0];

  // Clamp a direction row sum
  assign row_fits  = (&row_s[ROW_W-1:31]) | ~(|row_s[ROW_W-1:31]);
  assign clamp_res = row_fits ? row_s[31:0] : (row_s[ROW_W-1] ? MIN_S32 : MAX_S32);

  // Matrix registers, identity after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) begin
        mat_q[i] <= (i % 5 == 0) ? ONE_Q : '0;
      end
    end else if (cmd_i.mat_we) begin
      mat_q[element_index_i] <= element_value_i;
    end
  end

  // Multiply-accumulate and divider registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      vec_q[0] <= in_x_i;
      vec_q[1] <= in_y_i;
      vec_q[2] <= in_z_i;
    end
    if (cmd_i.mul_en) begin
      prod_q <= $signed(mat_rd) * vec_sel;
    end
    if (cmd_i.acc_init) begin
      acc_q <= cmd_i.with_trans ? (ACC_W'($signed(mat_rd)) <<< FRAC_BITS) : '0;
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
    if (cmd_i.store_w) begin
      w_q <= row_s;
    end
    if (cmd_i.div_ld) begin
      div_n_q   <= num_mag;
      div_d_q   <= den_mag;
      div_r_q   <= {1'b0, rem0};
      div_neg_q <= row_s[ROW_W-1] ^ w_q[ROW_W-1];
      div_ovf_q <= (rem0 >= den_mag);
      div_quo_q <= '0;
    end else if (cmd_i.div_step) begin
      div_r_q   <= rem_ge ? (rem_sh - {1'b0, div_d_q}) : rem_sh;
      div_quo_q <= {div_quo_q[DIV_QW-2:0], rem_ge};
    end
  end

  // Result registers, cleared as each item starts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q[0] <= '0;
      res_q[1] <= '0;
      res_q[2] <= '0;
      dz_q     <= 1'b0;
      sat_q    <= 1'b0;
    end else if (cmd_i.capture) begin
      res_q[0] <= '0;
      res_q[1] <= '0;
      res_q[2] <= '0;
      dz_q     <= 1'b0;
      sat_q    <= 1'b0;
    end else begin
      if (cmd_i.set_dz) begin
        dz_q <= 1'b1;
      end
      if (cmd_i.store_clamp) begin
        res_q[cmd_i.row] <= clamp_res;
        sat_q            <= sat_q | ~row_fits;
      end
      if (cmd_i.store_div) begin
        res_q[cmd_i.row] <= div_res;
        sat_q            <= sat_q | quo_sat;
      end
    end
  end

  // Output register, holds a finished word until taken
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_x_q   <= res_q[0];
      out_y_q   <= res_q[1];
      out_z_q   <= res_q[2];
      out_dz_q  <= dz_q;
      out_sat_q <= sat_q;
    end
  end

  assign out_x_o          = out_x_q;
  assign out_y_o          = out_y_q;
  assign out_z_o          = out_z_q;
  assign divide_by_zero_o = out_dz_q;
  assign saturated_o      = out_sat_q;

endmodule

### bench/tb_top.sv
// Self-checking bench for homogeneous_point_transform: directed table, then random words.
// Uses its own copy of the matrix to predict results, unless a directed row gives one.
// Depends on hpt_pkg and the RTL under rtl/core.
module tb_top;
  import hpt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 150;
  localparam int WORDS_PER_PHASE = 383;
  localparam logic [1:0] OP_SPARE = 2'd3;

  localparam logic signed [31:0] ONE_FX = 32'sh0001_0000;
  localparam logic signed [31:0] MAXV = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] MINV = 32'sh8000_0000;
  localparam logic signed [66:0] WIDE_MAX = 67'sd2147483647;
  localparam logic signed [66:0] WIDE_MIN = -67'sd2147483648;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               dz;
    logic               sat;
  } coord_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [3:0]         idx;
    logic signed [31:0] val;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               typed;
    coord_t             want;
  } stim_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [1:0]         operation_i = OP_LOAD;
  logic [3:0]         element_index_i = '0;
  logic signed [31:0] element_value_i = '0;
  logic signed [31:0] in_x_i = '0;
  logic signed [31:0] in_y_i = '0;
  logic signed [31:0] in_z_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [31:0] out_x_o;
  logic signed [31:0] out_y_o;
  logic signed [31:0] out_z_o;
  logic               divide_by_zero_o;
  logic               saturated_o;

  logic signed [31:0] matrix_copy [16];
  coord_t             pending_coords [$];
  stim_row_t          directed_rows [$];
  int                 send_idle_pct = 37;
  int                 recv_idle_pct = 67;
  int                 mismatches = 0;
  int                 cycle_count = 0;

  homogeneous_point_transform u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .operation_i      (operation_i),
    .element_index_i  (element_index_i),
    .element_value_i  (element_value_i),
    .in_x_i           (in_x_i),
    .in_y_i           (in_y_i),
    .in_z_i           (in_z_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_x_o          (out_x_o),
    .out_y_o          (out_y_o),
    .out_z_o          (out_z_o),
    .divide_by_zero_o (divide_by_zero_o),
    .saturated_o      (saturated_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Abandon the run if it hangs
  always @(posedge clk_i) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Row sum: exact products, floor to the fixed-point grid, then the translation term
  function automatic logic signed [66:0] row_total(int unsigned r, logic signed [31:0] vx,
                                                   logic signed [31:0] vy,
                                                   logic signed [31:0] vz, logic with_trans);
    logic signed [66:0] acc;
    acc = 67'(matrix_copy[r*4]) * 67'(vx) + 67'(matrix_copy[r*4+1]) * 67'(vy)
        + 67'(matrix_copy[r*4+2]) * 67'(vz);
    acc = acc >>> FRAC_BITS;
    if (with_trans) acc = acc + 67'(matrix_copy[r*4+3]);
    return acc;
  endfunction

  // Quotient num * 2^FRAC_BITS / den, rounded toward zero, clamped to 32 bits
  function automatic logic signed [31:0] scaled_quotient(logic signed [66:0] num,
                                                         logic signed [66:0] den,
                                                         inout logic sat);
    logic [127:0] n, d, q, lim;
    logic         neg;
    neg = (num < 0) != (den < 0);
    n = (num < 0) ? 128'(-num) : 128'(num);
    d = (den < 0) ? 128'(-den) : 128'(den);
    q = (n << FRAC_BITS) / d;
    lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (q > lim) begin
      sat = 1'b1;
      q = lim;
    end
    return neg ? 32'(32'd0 - q[31:0]) : q[31:0];
  endfunction

  // Expected result of a point or direction word against the current matrix
  function automatic coord_t transform_word(logic [1:0] op, logic signed [31:0] vx,
                                            logic signed [31:0] vy, logic signed [31:0] vz);
    coord_t             res;
    logic signed [66:0] w, s;
    logic signed [31:0] c [3];
    logic               sat;
    res = '0;
    sat = 1'b0;
    for (int k = 0; k < 3; k++) c[k] = '0;
    if (op == OP_POINT) begin
      w = row_total(3, vx, vy, vz, 1'b1);
      if (w == 0) begin
        res.dz = 1'b1;
      end else begin
        for (int k = 0; k < 3; k++) begin
          c[k] = scaled_quotient(row_total(k, vx, vy, vz, 1'b1), w, sat);
        end
      end
    end else begin
      for (int k = 0; k < 3; k++) begin
        s = row_total(k, vx, vy, vz, 1'b0);
        if (s > WIDE_MAX) begin
          c[k] = MAXV;
          sat = 1'b1;
        end else if (s < WIDE_MIN) begin
          c[k] = MINV;
          sat = 1'b1;
        end else begin
          c[k] = s[31:0];
        end
      end
    end
    res.x = c[0];
    res.y = c[1];
    res.z = c[2];
    res.sat = sat;
    return res;
  endfunction

  function automatic logic signed [31:0] pick_value();
    logic signed [31:0] v;
    case ($urandom_range(15))
      0: v = '0;
      1: v = ONE_FX;
      2: v = -ONE_FX;
      3: v = MAXV;
      4: v = MINV;
      5, 6, 7: v = $urandom;
      // mostly within +/-8.0 so that results stay meaningful
      default: v = 32'($urandom_range(1 << 20)) - 32'sd524288;
    endcase
    return v;
  endfunction

  function automatic void row_typed(logic [1:0] op, logic [3:0] idx, logic signed [31:0] val,
                                    logic signed [31:0] x, logic signed [31:0] y,
                                    logic signed [31:0] z, logic signed [31:0] ex,
                                    logic signed [31:0] ey, logic signed [31:0] ez,
                                    logic edz, logic esat);
    stim_row_t r;
    r.op = op;
    r.idx = idx;
    r.val = val;
    r.x = x;
    r.y = y;
    r.z = z;
    r.typed = 1'b1;
    r.want = {ex, ey, ez, edz, esat};
    directed_rows.push_back(r);
  endfunction

  function automatic void row_pred(logic [1:0] op, logic [3:0] idx, logic signed [31:0] val,
                                   logic signed [31:0] x, logic signed [31:0] y,
                                   logic signed [31:0] z);
    stim_row_t r;
    r.op = op;
    r.idx = idx;
    r.val = val;
    r.x = x;
    r.y = y;
    r.z = z;
    r.typed = 1'b0;
    r.want = '0;
    directed_rows.push_back(r);
  endfunction

  // Offer a word until in_ready_o is high, then update the matrix copy or queue the result
  task automatic send_word(input logic [1:0] op, input logic [3:0] idx,
                           input logic signed [31:0] val, input logic signed [31:0] x,
                           input logic signed [31:0] y, input logic signed [31:0] z,
                           input logic typed, input coord_t want);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    element_index_i <= idx;
    element_value_i <= val;
    in_x_i <= x;
    in_y_i <= y;
    in_z_i <= z;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (op == OP_LOAD) begin
      matrix_copy[idx] = val;
    end else if (op == OP_POINT || op == OP_DIR) begin
      pending_coords.push_back(typed ? want : transform_word(op, x, y, z));
    end
  endtask

  // Hold off the sender until every queued result has come back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_coords.size() != 0) @(posedge clk_i);
  endtask

  // Take results at a random rate and check each against the oldest expectation
  always @(posedge clk_i) begin
    coord_t got, want;
    if (out_valid_o && out_ready_i) begin
      got = {out_x_o, out_y_o, out_z_o, divide_by_zero_o, saturated_o};
      if (pending_coords.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10)
          $display("unexpected result x=%h y=%h z=%h dz=%b sat=%b",
                   got.x, got.y, got.z, got.dz, got.sat);
      end else begin
        want = pending_coords.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
            got.dz !== want.dz || got.sat !== want.sat) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("mismatch: expected %h %h %h %b %b, got %h %h %h %b %b",
                     want.x, want.y, want.z, want.dz, want.sat,
                     got.x, got.y, got.z, got.dz, got.sat);
        end
      end
    end
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    stim_row_t   r;
    int          counted;
    int          sel;
    logic [1:0]  op;
    logic [3:0]  idx;
    logic signed [31:0] val;
    int          send_pct [3];
    int          recv_pct [3];

    send_pct = '{37, 67, 0};
    recv_pct = '{67, 37, 0};
    for (int i = 0; i < 16; i++) matrix_copy[i] = (i % 5 == 0) ? ONE_FX : '0;

    // Hold reset low, then release it on a rising edge
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Identity after reset passes points and directions through, even at the extremes
    row_typed(OP_POINT, 4'd0, 32'sd0, MINV, MAXV, 32'sd0, MINV, MAXV, 32'sd0, 1'b0, 1'b0);
    row_typed(OP_DIR, 4'd0, 32'sd0, MAXV, MINV, 32'sd12345, MAXV, MINV, 32'sd12345, 1'b0, 1'b0);
    row_pred(OP_SPARE, 4'd15, MINV, MAXV, MAXV, MAXV);
    // Zero w: flag set, coordinates zero; directions unaffected
    row_pred(OP_LOAD, 4'd15, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
    row_typed(OP_POINT, 4'd0, 32'sd0, ONE_FX, ONE_FX, ONE_FX, 32'sd0, 32'sd0, 32'sd0, 1'b1, 1'b0);
    row_typed(OP_DIR, 4'd0, 32'sd0, ONE_FX, 2 * ONE_FX, 3 * ONE_FX,
              ONE_FX, 2 * ONE_FX, 3 * ONE_FX, 1'b0, 1'b0);
    row_pred(OP_LOAD, 4'd15, ONE_FX, 32'sd0, 32'sd0, 32'sd0);
    // Extreme coefficients force saturation both ways
    row_pred(OP_LOAD, 4'd0, MAXV, 32'sd0, 32'sd0, 32'sd0);
    row_typed(OP_DIR, 4'd0, 32'sd0, MAXV, 32'sd0, 32'sd0, MAXV, 32'sd0, 32'sd0, 1'b0, 1'b1);
    row_typed(OP_POINT, 4'd0, 32'sd0, MINV, 32'sd0, 32'sd0, MINV, 32'sd0, 32'sd0, 1'b0, 1'b1);
    row_pred(OP_LOAD, 4'd0, MINV, 32'sd0, 32'sd0, 32'sd0);
    row_typed(OP_DIR, 4'd0, 32'sd0, MINV, 32'sd0, 32'sd0, MAXV, 32'sd0, 32'sd0, 1'b0, 1'b1);
    row_pred(OP_LOAD, 4'd0, ONE_FX, 32'sd0, 32'sd0, 32'sd0);
    // Translation and a z-dependent w
    row_pred(OP_LOAD, 4'd3, 5 * ONE_FX, 32'sd0, 32'sd0, 32'sd0);
    row_pred(OP_LOAD, 4'd7, -3 * ONE_FX, 32'sd0, 32'sd0, 32'sd0);
    row_pred(OP_LOAD, 4'd14, ONE_FX, 32'sd0, 32'sd0, 32'sd0);
    row_pred(OP_POINT, 4'd0, 32'sd0, 2 * ONE_FX, -ONE_FX, 3 * ONE_FX);
    row_typed(OP_POINT, 4'd0, 32'sd0, 32'sd0, 32'sd0, -ONE_FX,
              32'sd0, 32'sd0, 32'sd0, 1'b1, 1'b0);
    row_pred(OP_POINT, 4'd0, 32'sd0, 7 * ONE_FX, 32'sd1, -2 * ONE_FX);
    row_pred(OP_LOAD, 4'd12, MAXV, 32'sd0, 32'sd0, 32'sd0);
    row_pred(OP_POINT, 4'd0, 32'sd0, 32'sd3, -ONE_FX, ONE_FX);
    row_pred(OP_LOAD, 4'd12, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
    row_pred(OP_LOAD, 4'd14, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
    row_pred(OP_SPARE, 4'd5, MINV, 32'sd0, 32'sd0, 32'sd0);
    row_pred(OP_DIR, 4'd0, 32'sd0, ONE_FX, ONE_FX, ONE_FX);

    foreach (directed_rows[i]) begin
      r = directed_rows[i];
      send_word(r.op, r.idx, r.val, r.x, r.y, r.z, r.typed, r.want);
    end

    // Random words in three phases of idling, draining fully between phases
    for (int p = 0; p < 3; p++) begin
      drain_results();
      send_idle_pct = send_pct[p];
      recv_idle_pct = recv_pct[p];
      counted = 0;
      while (counted < WORDS_PER_PHASE) begin
        sel = $urandom_range(99);
        idx = 4'($urandom);
        val = $urandom;
        if (sel < 28) begin
          op = OP_LOAD;
          val = pick_value();
        end else if (sel < 34) begin
          // clear part of the w row so that zero w turns up
          op = OP_LOAD;
          idx = 4'd12 + 4'($urandom_range(3));
          val = '0;
        end else if (sel < 66) begin
          op = OP_POINT;
        end else if (sel < 96) begin
          op = OP_DIR;
        end else begin
          op = OP_SPARE;
        end
        if (op == OP_LOAD)
          send_word(op, idx, val, $urandom, $urandom, $urandom, 1'b0, '0);
        else
          send_word(op, idx, val, pick_value(), pick_value(), pick_value(), 1'b0, '0);
        if (op != OP_SPARE) counted++;
      end
    end

    // Wait for the last results, then watch for strays
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    mismatches = mismatches + pending_coords.size();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/hpt_pkg.sv
rtl/core/hpt_ctrl.sv
rtl/core/hpt_datapath.sv
rtl/core/homogeneous_point_transform.sv
bench/tb_top.sv
